>>> design/eqp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge qualify pulse package
// Widths, reset values, phase codes and register indexes shared by the
// three-channel edge qualify pulse block.
// ----------------------------------------------------------------------------
package eqp_pkg;

	localparam int NUM_CHANNELS = 3;
	localparam int QUAL_W       = 8;
	localparam int PULSE_W      = 10;
	localparam int COUNT_W      = 10;
	localparam int PHASE_W      = 2;
	localparam int CHAN_W       = 2;
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;

	localparam logic [QUAL_W-1:0]   QUALIFY_TICKS_RESET = 8'd5;
	localparam logic [PULSE_W-1:0]  PULSE_TICKS_RESET   = 10'd10;
	localparam logic [COUNT_W-1:0]  COUNT_MAX           = 10'd1023;
	localparam logic [COUNT_W-1:0]  COUNT_ONE           = 10'd1;

	// Phase codes.
	localparam logic [PHASE_W-1:0] PHASE_IDLE  = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_QUAL  = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_PULSE = 2'd2;

	// Channel codes.
	localparam logic [CHAN_W-1:0] CHAN_ONE   = 2'd0;
	localparam logic [CHAN_W-1:0] CHAN_TWO   = 2'd1;
	localparam logic [CHAN_W-1:0] CHAN_THREE = 2'd2;

	// Register indexes, taken from paddr bit 2.
	localparam logic REG_QUALIFY_TICKS = 1'b0;
	localparam logic REG_PULSE_TICKS   = 1'b1;

endpackage

>>> design/edge_qualify_pulse_three_channel.sv
`timescale 1ns / 1ps
// The result of each accepted item is registered straight into the output register.
// Throughput: one item per clock; an item is taken when the output register is empty or
// its result leaves in the same cycle, so a waiting result holds off the input.
// The per-tick sequencer and counters update in the accept cycle, so nothing else limits the rate.
// Reset (arst_n low, asynchronous): edge flags, snapshot and phase clear, counters go to zero,
// qualify_ticks returns to 5 and pulse_ticks to 10, and the output register empties.
// ----------------------------------------------------------------------------
// Edge qualify pulse, three channels
// Latches rising edges of three detect levels, qualifies each latched channel
// for a programmable number of ticks and then drives its mapped hit output and
// the LED for a programmable number of ticks.
// ----------------------------------------------------------------------------
module edge_qualify_pulse_three_channel (
	input  logic                         clk,
	input  logic                         arst_n,
	// Tick items in.
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         level_one,
	input  logic                         level_two,
	input  logic                         level_three,
	// Result items out.
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit_one,
	output logic                         hit_two,
	output logic                         hit_three,
	output logic                         led_on,
	output logic                         busy_res,
	// Configuration port.
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [eqp_pkg::PADDR_W-1:0]  paddr,
	input  logic [eqp_pkg::PDATA_W-1:0]  pwdata,
	output logic [eqp_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	// ------------------------------------------------------------------
	// Configuration registers. Writes complete in the access phase; the
	// port never stalls.
	// ------------------------------------------------------------------
	logic [eqp_pkg::QUAL_W-1:0]  qualify_ticks_q;
	logic [eqp_pkg::PULSE_W-1:0] pulse_ticks_q;
	logic                        cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qualify_ticks_q <= eqp_pkg::QUALIFY_TICKS_RESET;
			pulse_ticks_q   <= eqp_pkg::PULSE_TICKS_RESET;
		end else if (cfg_write) begin
			if (paddr[2] == eqp_pkg::REG_QUALIFY_TICKS) begin
				qualify_ticks_q <= pwdata[eqp_pkg::QUAL_W-1:0];
			end else begin
				pulse_ticks_q <= pwdata[eqp_pkg::PULSE_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == eqp_pkg::REG_QUALIFY_TICKS) begin
			prdata[eqp_pkg::QUAL_W-1:0] = qualify_ticks_q;
		end else begin
			prdata[eqp_pkg::PULSE_W-1:0] = pulse_ticks_q;
		end
	end

	// ------------------------------------------------------------------
	// Handshake. The output register is the only buffer; a new item is
	// taken whenever that register is empty or is being emptied.
	// ------------------------------------------------------------------
	logic accept;

	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Tick state.
	// ------------------------------------------------------------------
	logic [eqp_pkg::NUM_CHANNELS-1:0] prev_levels_q;
	logic [eqp_pkg::NUM_CHANNELS-1:0] pending_q;
	logic [eqp_pkg::NUM_CHANNELS-1:0] snapshot_q;
	logic [eqp_pkg::PHASE_W-1:0]      phase_q;
	logic [eqp_pkg::CHAN_W-1:0]       active_q;
	logic [eqp_pkg::COUNT_W-1:0]      count_q;

	logic [eqp_pkg::NUM_CHANNELS-1:0] levels;
	logic [eqp_pkg::NUM_CHANNELS-1:0] pending_edges;
	logic [eqp_pkg::NUM_CHANNELS-1:0] work_snapshot;
	logic [eqp_pkg::NUM_CHANNELS-1:0] pending_d;
	logic [eqp_pkg::NUM_CHANNELS-1:0] snapshot_d;
	logic [eqp_pkg::PHASE_W-1:0]      phase_d;
	logic [eqp_pkg::CHAN_W-1:0]       active_d;
	logic [eqp_pkg::COUNT_W-1:0]      count_d;
	logic [eqp_pkg::COUNT_W-1:0]      count_inc;
	logic                             active_level;
	logic [eqp_pkg::CHAN_W-1:0]       first_chan;
	logic                             first_level;

	assign levels        = {level_three, level_two, level_one};
	// Rising edges join the pending set first, so an edge can be served
	// on the tick it arrives.
	assign pending_edges = pending_q | (levels & ~prev_levels_q);
	// A stored count never passes COUNT_MAX in the qualify phase.
	assign count_inc     = (count_q < eqp_pkg::COUNT_MAX) ? count_q + eqp_pkg::COUNT_ONE
	                                                      : count_q;

	// Level of the channel under service; an unused channel code reads low.
	always_comb begin
		case (active_q)
			eqp_pkg::CHAN_ONE:   active_level = levels[0];
			eqp_pkg::CHAN_TWO:   active_level = levels[1];
			eqp_pkg::CHAN_THREE: active_level = levels[2];
			default:             active_level = 1'b0;
		endcase
	end

	// When the snapshot is empty in the idle phase it takes all pending
	// edges; the lowest numbered channel in it is served first.
	assign work_snapshot = (snapshot_q == '0) ? pending_edges : snapshot_q;

	always_comb begin
		if (work_snapshot[0]) begin
			first_chan  = eqp_pkg::CHAN_ONE;
			first_level = levels[0];
		end else if (work_snapshot[1]) begin
			first_chan  = eqp_pkg::CHAN_TWO;
			first_level = levels[1];
		end else begin
			first_chan  = eqp_pkg::CHAN_THREE;
			first_level = levels[2];
		end
	end

	always_comb begin
		pending_d  = pending_edges;
		snapshot_d = snapshot_q;
		phase_d    = phase_q;
		active_d   = active_q;
		count_d    = count_q;
		unique case (phase_q)
			eqp_pkg::PHASE_QUAL: begin
				// Any low sample ends the attempt with the outputs off.
				if (!active_level) begin
					phase_d = eqp_pkg::PHASE_IDLE;
					count_d = '0;
				end else if (count_inc >= {2'b00, qualify_ticks_q}) begin
					phase_d = eqp_pkg::PHASE_PULSE;
					count_d = eqp_pkg::COUNT_ONE;
				end else begin
					count_d = count_inc;
				end
			end
			eqp_pkg::PHASE_PULSE: begin
				if (count_q >= pulse_ticks_q) begin
					phase_d = eqp_pkg::PHASE_IDLE;
					count_d = '0;
				end else begin
					count_d = count_q + eqp_pkg::COUNT_ONE;
				end
			end
			default: begin
				// Idle, and the unused code behaves as idle.
				phase_d = eqp_pkg::PHASE_IDLE;
				if (snapshot_q == '0) begin
					pending_d = '0;
				end
				snapshot_d = work_snapshot;
				if (work_snapshot != '0) begin
					snapshot_d[first_chan] = 1'b0;
					active_d               = first_chan;
					count_d                = '0;
					if (first_level) begin
						phase_d = eqp_pkg::PHASE_QUAL;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_levels_q <= '0;
			pending_q     <= '0;
			snapshot_q    <= '0;
			phase_q       <= eqp_pkg::PHASE_IDLE;
			active_q      <= eqp_pkg::CHAN_ONE;
			count_q       <= '0;
		end else if (accept) begin
			prev_levels_q <= levels;
			pending_q     <= pending_d;
			snapshot_q    <= snapshot_d;
			phase_q       <= phase_d;
			active_q      <= active_d;
			count_q       <= count_d;
		end
	end

	// ------------------------------------------------------------------
	// Result register. Hit mapping is crossed: channel 1 drives hit_two
	// and channel 2 drives hit_one; channel 3 drives hit_three.
	// ------------------------------------------------------------------
	logic pulsing;
	logic hit_one_d;
	logic hit_two_d;
	logic hit_three_d;
	logic out_valid_q;
	logic hit_one_q;
	logic hit_two_q;
	logic hit_three_q;
	logic led_on_q;
	logic busy_q;

	assign pulsing     = (phase_d == eqp_pkg::PHASE_PULSE);
	assign hit_two_d   = pulsing && (active_d == eqp_pkg::CHAN_ONE);
	assign hit_one_d   = pulsing && (active_d == eqp_pkg::CHAN_TWO);
	assign hit_three_d = pulsing && (active_d == eqp_pkg::CHAN_THREE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_one_q   <= hit_one_d;
			hit_two_q   <= hit_two_d;
			hit_three_q <= hit_three_d;
			led_on_q    <= hit_one_d | hit_two_d | hit_three_d;
			busy_q      <= (phase_d == eqp_pkg::PHASE_QUAL) || pulsing;
		end
	end

	assign out_valid = out_valid_q;
	assign hit_one   = hit_one_q;
	assign hit_two   = hit_two_q;
	assign hit_three = hit_three_q;
	assign led_on    = led_on_q;
	assign busy_res  = busy_q;

endmodule
